// ===== design/byte_line_deque_assert.svh =====
// Assertion macros for the byte line deque.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BYTE_LINE_DEQUE_ASSERT_SVH
`define BYTE_LINE_DEQUE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BLD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BLD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bld_pkg.sv =====
// Shared types, constants and index helpers for the byte line deque.
// No dependencies; used by byte_line_deque.
package bld_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [CW:0]   sum_t;

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP        = 3'd2,
    MODE_PEEK       = 3'd3,
    MODE_LINE_QUERY = 3'd4,
    MODE_READ_LINE  = 3'd5,
    MODE_FLUSH      = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_COMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       ok;
    logic       last;
    logic [6:0] fill_count;
    logic [6:0] line_length;
  } res_t;

  // Advance an index by one with wrap at DEPTH.
  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  // Step an index back by one with wrap at DEPTH.
  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

  // Add a count of at most DEPTH to an index with wrap at DEPTH.
  function automatic idx_t idx_add(idx_t i, cnt_t a);
    sum_t s;
    s = sum_t'(i) + sum_t'(a);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic is_term(logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// ===== design/bld_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bld_ram #(
  parameter int unsigned DEPTH_P = 64,
  parameter int unsigned WIDTH_P = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  logic [WIDTH_P-1:0]         wdata_i,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output logic [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/byte_line_deque.sv =====
// Byte line deque: pushes, flush and items on an empty store answer straight from idle; pop and peek
// read the front byte in a fetch state. Line query scans the held bytes in a scan state (up to the held count).
// Read line scans the same way, checks the follow-on terminator in a compare state
// when bytes remain, then streams one line byte per cycle; the RAM read port sets the pace.
// Results are registered, appear in the cycle after the cycle that produces them and cannot be stalled;
// busy_o stays high until then. Reset clears indices, count and control, not the store.
module byte_line_deque (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bld_pkg::item_t item_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output bld_pkg::res_t  res_o
);

  bld_pkg::state_e state_q, state_d;
  bld_pkg::idx_t   rd_q, rd_d, wr_q, wr_d, ptr_q, ptr_d;
  bld_pkg::cnt_t   cnt_q, cnt_d, n_q, n_d, drop_q, drop_d, left_q, left_d;
  logic            consume_q, consume_d;
  logic [7:0]      term_q, term_d;
  bld_pkg::res_t   res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic            mem_we;
  bld_pkg::idx_t   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;

  logic            emit_go;
  bld_pkg::cnt_t   drop_c;
  logic [7:0]      comp_c;

  bld_ram #(
    .DEPTH_P (bld_pkg::DEPTH),
    .WIDTH_P (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Hold control state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bld_pkg::ST_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Hold working values of the current item.
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    n_q       <= n_d;
    drop_q    <= drop_d;
    left_q    <= left_d;
    consume_q <= consume_d;
    term_q    <= term_d;
    res_q     <= res_d;
  end

  // Sequence each item through the RAM.
  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    n_d         = n_q;
    drop_d      = drop_q;
    left_d      = left_q;
    consume_d   = consume_q;
    term_d      = term_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_q;
    mem_wdata   = item_i.data_byte;
    mem_raddr   = ptr_q;
    emit_go     = 1'b0;
    drop_c      = n_q;
    comp_c      = (term_q == bld_pkg::CH_LF) ? bld_pkg::CH_CR : bld_pkg::CH_LF;

    case (state_q)
      bld_pkg::ST_IDLE: begin
        if (start_i) begin
          res_d.last       = 1'b1;
          res_d.fill_count = 7'(cnt_q);
          case (item_i.mode)
            bld_pkg::MODE_PUSH_BACK: begin
              res_valid_d = 1'b1;
              if (cnt_q != bld_pkg::cnt_t'(bld_pkg::DEPTH)) begin
                mem_we           = 1'b1;
                mem_waddr        = wr_q;
                wr_d             = bld_pkg::idx_inc(wr_q);
                cnt_d            = cnt_q + bld_pkg::cnt_t'(1);
                res_d.ok         = 1'b1;
                res_d.fill_count = 7'(cnt_q + bld_pkg::cnt_t'(1));
              end
            end
            bld_pkg::MODE_PUSH_FRONT: begin
              res_valid_d = 1'b1;
              if (cnt_q != bld_pkg::cnt_t'(bld_pkg::DEPTH)) begin
                mem_we           = 1'b1;
                mem_waddr        = bld_pkg::idx_dec(rd_q);
                rd_d             = bld_pkg::idx_dec(rd_q);
                cnt_d            = cnt_q + bld_pkg::cnt_t'(1);
                res_d.ok         = 1'b1;
                res_d.fill_count = 7'(cnt_q + bld_pkg::cnt_t'(1));
              end
            end
            bld_pkg::MODE_POP, bld_pkg::MODE_PEEK: begin
              if (cnt_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                mem_raddr = rd_q;
                consume_d = (item_i.mode == bld_pkg::MODE_POP);
                state_d   = bld_pkg::ST_FETCH;
              end
            end
            bld_pkg::MODE_LINE_QUERY, bld_pkg::MODE_READ_LINE: begin
              if (cnt_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                mem_raddr = rd_q;
                ptr_d     = bld_pkg::idx_inc(rd_q);
                n_d       = bld_pkg::cnt_t'(1);
                consume_d = (item_i.mode == bld_pkg::MODE_READ_LINE);
                state_d   = bld_pkg::ST_SCAN;
              end
            end
            bld_pkg::MODE_FLUSH: begin
              res_valid_d      = 1'b1;
              rd_d             = '0;
              wr_d             = '0;
              cnt_d            = '0;
              res_d.ok         = 1'b1;
              res_d.fill_count = '0;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      // Deliver the front byte; drop it for a pop.
      bld_pkg::ST_FETCH: begin
        res_valid_d      = 1'b1;
        res_d.out_byte   = mem_rdata;
        res_d.byte_valid = 1'b1;
        res_d.ok         = 1'b1;
        res_d.last       = 1'b1;
        res_d.fill_count = 7'(cnt_q);
        if (consume_q) begin
          rd_d             = bld_pkg::idx_inc(rd_q);
          cnt_d            = cnt_q - bld_pkg::cnt_t'(1);
          res_d.fill_count = 7'(cnt_q - bld_pkg::cnt_t'(1));
        end
        state_d = bld_pkg::ST_IDLE;
      end

      // Walk the held bytes one per cycle looking for CR or LF.
      bld_pkg::ST_SCAN: begin
        if (bld_pkg::is_term(mem_rdata)) begin
          if (!consume_q) begin
            res_valid_d       = 1'b1;
            res_d.ok          = 1'b1;
            res_d.last        = 1'b1;
            res_d.fill_count  = 7'(cnt_q);
            res_d.line_length = 7'(n_q);
            state_d           = bld_pkg::ST_IDLE;
          end else begin
            term_d = mem_rdata;
            if (cnt_q != n_q) begin
              state_d = bld_pkg::ST_COMP;
            end else begin
              emit_go = 1'b1;
            end
          end
        end else if (n_q == cnt_q) begin
          res_valid_d      = 1'b1;
          res_d.last       = 1'b1;
          res_d.fill_count = 7'(cnt_q);
          state_d          = bld_pkg::ST_IDLE;
        end else begin
          ptr_d = bld_pkg::idx_inc(ptr_q);
          n_d   = n_q + bld_pkg::cnt_t'(1);
        end
      end

      // Drop a complementary terminator that directly follows.
      bld_pkg::ST_COMP: begin
        emit_go = 1'b1;
        if (mem_rdata == comp_c) begin
          drop_c = n_q + bld_pkg::cnt_t'(1);
        end
      end

      // Stream line bytes, one per cycle.
      bld_pkg::ST_EMIT: begin
        res_valid_d      = 1'b1;
        res_d.out_byte   = mem_rdata;
        res_d.byte_valid = 1'b1;
        res_d.ok         = 1'b1;
        res_d.last       = (left_q == bld_pkg::cnt_t'(1));
        res_d.fill_count = 7'(cnt_q - drop_q);
        ptr_d            = bld_pkg::idx_inc(ptr_q);
        left_d           = left_q - bld_pkg::cnt_t'(1);
        if (left_q == bld_pkg::cnt_t'(1)) begin
          rd_d    = bld_pkg::idx_add(rd_q, drop_q);
          cnt_d   = cnt_q - drop_q;
          state_d = bld_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bld_pkg::ST_IDLE;
      end
    endcase

    // Begin line delivery once the dropped length is known.
    if (emit_go) begin
      drop_d = drop_c;
      if (n_q == bld_pkg::cnt_t'(1)) begin
        res_valid_d      = 1'b1;
        res_d.ok         = 1'b1;
        res_d.last       = 1'b1;
        res_d.fill_count = 7'(cnt_q - drop_c);
        rd_d             = bld_pkg::idx_add(rd_q, drop_c);
        cnt_d            = cnt_q - drop_c;
        state_d          = bld_pkg::ST_IDLE;
      end else begin
        mem_raddr = rd_q;
        ptr_d     = bld_pkg::idx_inc(rd_q);
        left_d    = n_q - bld_pkg::cnt_t'(1);
        state_d   = bld_pkg::ST_EMIT;
      end
    end
  end

  assign busy_o      = (state_q != bld_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `include "byte_line_deque_assert.svh"

  `BLD_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= bld_pkg::cnt_t'(bld_pkg::DEPTH), "count above depth")
  `BLD_ASSERT_IMP(a_idx_track, 1'b1, bld_pkg::idx_add(rd_q, cnt_q) == wr_q, "indices out of step")
  `BLD_ASSERT_NXT(a_line_burst, res_valid_q && !res_q.last, res_valid_q, "line burst broken")
  `BLD_ASSERT_NXT(a_accept_prog, start_i && !busy_o, res_valid_q || busy_o, "accepted item lost")
  `BLD_ASSERT_IMP(a_byte_ok, res_valid_q && res_q.byte_valid, res_q.ok, "byte without ok")

endmodule
